// ===== hdl/cra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cra_pkg
// Shared types and sizes for the cooldown resource arbiter.
// ---------------------------------------------------------------------------
package cra_pkg;

    localparam int WAITER_SLOTS = 8;
    localparam int SLOT_W       = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int CNT_W        = $clog2(WAITER_SLOTS + 1);
    localparam int TREE_LEAVES  = 1 << SLOT_W;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_CANCEL  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_COOLDOWN = 2'd0,
        CFG_EDF_MODE = 2'd1,
        CFG_BURNOUT  = 2'd2
    } cfg_reg_t;

    // One contender in the selection tree; a smaller key wins
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] idx;
        logic [7:0]        client;
        logic [63:0]       key;
    } cand_t;

    typedef struct packed {
        logic        insert;
        logic        cancel;
        logic [7:0]  client;
        logic [31:0] arrival;
        logic [31:0] deadline;
        logic        edf;
    } table_op_t;

    typedef struct packed {
        logic             full;
        logic             best_valid;
        logic [7:0]       best_client;
        logic [CNT_W-1:0] count;
    } table_stat_t;

endpackage

`default_nettype wire

// ===== hdl/cra_pick.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cra_pick
// Binary compare tree that finds the best valid waiter, ties to lowest slot.
// ---------------------------------------------------------------------------
module cra_pick
    import cra_pkg::*;
(
    input  wire cand_t leaf [WAITER_SLOTS],
    output cand_t best
);

    cand_t node [1:2*TREE_LEAVES-1];

    always_comb begin
        for (int i = 0; i < TREE_LEAVES; i++) begin
            if (i < WAITER_SLOTS) begin
                node[TREE_LEAVES+i] = leaf[i];
            end else begin
                node[TREE_LEAVES+i] = '0;
            end
        end
        // left child holds lower slots: take the right one only if strictly better
        for (int n = TREE_LEAVES - 1; n >= 1; n--) begin
            if (node[2*n+1].valid &&
                (!node[2*n].valid || (node[2*n+1].key < node[2*n].key))) begin
                node[n] = node[2*n+1];
            end else begin
                node[n] = node[2*n];
            end
        end
    end

    assign best = node[1];

endmodule

`default_nettype wire

// ===== hdl/cra_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cra_table
// Waiter slots: insert, cancel, best-waiter selection and removal on grant.
// ---------------------------------------------------------------------------
module cra_table
    import cra_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire table_op_t op,
    input  wire         grant,
    output table_stat_t stat
);

    logic [WAITER_SLOTS-1:0] valid_reg;
    logic [WAITER_SLOTS-1:0] valid_post;
    logic [WAITER_SLOTS-1:0] valid_next;
    logic [7:0]              client_reg   [WAITER_SLOTS];
    logic [31:0]             arrival_reg  [WAITER_SLOTS];
    logic [31:0]             deadline_reg [WAITER_SLOTS];

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              cancel_found;
    logic [SLOT_W-1:0] cancel_idx;
    logic              ins_hit;
    logic [31:0]       arr_sel;
    logic [31:0]       dl_sel;
    logic [CNT_W-1:0]  count;

    cand_t leaf [WAITER_SLOTS];
    cand_t best;

    always_comb begin
        free_found   = 1'b0;
        free_idx     = '0;
        cancel_found = 1'b0;
        cancel_idx   = '0;
        for (int i = 0; i < WAITER_SLOTS; i++) begin
            if (!valid_reg[i] && !free_found) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (valid_reg[i] && (client_reg[i] == op.client) && !cancel_found) begin
                cancel_found = 1'b1;
                cancel_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        valid_post = valid_reg;
        if (op.insert && free_found) begin
            valid_post[free_idx] = 1'b1;
        end
        if (op.cancel && cancel_found) begin
            valid_post[cancel_idx] = 1'b0;
        end
    end

    // Leaves see the table as it stands after this word's insert or cancel
    always_comb begin
        for (int i = 0; i < WAITER_SLOTS; i++) begin
            ins_hit = op.insert && free_found && (free_idx == SLOT_W'(i));
            arr_sel = ins_hit ? op.arrival  : arrival_reg[i];
            dl_sel  = ins_hit ? op.deadline : deadline_reg[i];
            leaf[i].valid  = valid_post[i];
            leaf[i].idx    = SLOT_W'(i);
            leaf[i].client = ins_hit ? op.client : client_reg[i];
            leaf[i].key    = op.edf ? {dl_sel, arr_sel} : {32'd0, arr_sel};
        end
    end

    cra_pick u_pick (
        .leaf (leaf),
        .best (best)
    );

    always_comb begin
        valid_next = valid_post;
        if (grant) begin
            valid_next[best.idx] = 1'b0;
        end
        count = '0;
        for (int i = 0; i < WAITER_SLOTS; i++) begin
            count = count + CNT_W'(valid_next[i]);
        end
    end

    assign stat.full        = ~free_found;
    assign stat.best_valid  = best.valid;
    assign stat.best_client = best.client;
    assign stat.count       = count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.insert && free_found) begin
            client_reg[free_idx]   <= op.client;
            arrival_reg[free_idx]  <= op.arrival;
            deadline_reg[free_idx] <= op.deadline;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cooldown_resource_arbiter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cooldown_resource_arbiter
// Shared-resource arbiter with cooldown, EDF or FIFO order over waiter slots.
// ---------------------------------------------------------------------------
// A word is held in the input register; its result goes to the output register.
// Throughput: one word per cycle while the result channel does not stall; each
// word updates the clock, busy state and slot table and runs the slot compare tree at once.
// Reset (synchronous, active low) clears the slot table, counters, the busy
// flag and all configuration registers; no clearing pass is needed.
// ---------------------------------------------------------------------------
module cooldown_resource_arbiter
    import cra_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_addr,
    input  wire  [31:0] cfg_wdata,

    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_action,
    input  wire  [7:0]  s_requester_id,
    input  wire  [31:0] s_last_start_ms,

    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_granted,
    output logic [7:0]  m_granted_id,
    output logic        m_in_use,
    output logic [3:0]  m_waiting_count,
    output logic        m_request_dropped
);

    logic [31:0] cooldown_reg;
    logic        edf_reg;
    logic [31:0] burnout_reg;

    logic        in_valid_reg;
    action_t     act_reg;
    logic [7:0]  id_reg;
    logic [31:0] last_reg;

    logic [31:0] now_reg;
    logic [31:0] now_next;
    logic        busy_reg;
    logic        busy_post;
    logic        never_reg;
    logic [31:0] freed_reg;
    logic [31:0] freed_post;

    logic        m_valid_reg;
    logic        granted_reg;
    logic [7:0]  granted_id_reg;
    logic        in_use_reg;
    logic [3:0]  count_reg;
    logic        dropped_reg;

    logic        fire;
    logic        do_tick;
    logic        do_release;
    logic [32:0] dl_sum;
    logic [31:0] elapsed;
    logic        grant;
    logic [CNT_W+3:0] count_ext;

    table_op_t   op;
    table_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cooldown_reg <= '0;
            edf_reg      <= 1'b0;
            burnout_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_COOLDOWN: cooldown_reg <= cfg_wdata;
                CFG_EDF_MODE: edf_reg      <= cfg_wdata[0];
                CFG_BURNOUT:  burnout_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            act_reg  <= action_t'(s_action);
            id_reg   <= s_requester_id;
            last_reg <= s_last_start_ms;
        end
    end

    // Saturate the deadline at all ones
    assign dl_sum = {1'b0, last_reg} + {1'b0, burnout_reg};

    assign do_tick    = fire && (act_reg == ACT_TICK);
    assign do_release = fire && (act_reg == ACT_RELEASE);

    assign op.insert   = fire && (act_reg == ACT_REQUEST);
    assign op.cancel   = fire && (act_reg == ACT_CANCEL);
    assign op.client   = id_reg;
    assign op.arrival  = now_reg;
    assign op.deadline = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
    assign op.edf      = edf_reg;

    assign now_next   = now_reg + {31'd0, do_tick};
    assign busy_post  = busy_reg && !do_release;
    assign freed_post = do_release ? now_reg : freed_reg;
    assign elapsed    = now_next - freed_post;
    assign grant      = fire && !busy_post && stat.best_valid &&
                        (never_reg || (elapsed >= cooldown_reg));

    cra_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .grant   (grant),
        .stat    (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg   <= '0;
            busy_reg  <= 1'b0;
            never_reg <= 1'b1;
            freed_reg <= '0;
        end else begin
            now_reg   <= now_next;
            busy_reg  <= busy_post || grant;
            never_reg <= never_reg && !grant;
            freed_reg <= freed_post;
        end
    end

    assign count_ext = {4'd0, stat.count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            granted_reg    <= grant;
            granted_id_reg <= grant ? stat.best_client : 8'd0;
            in_use_reg     <= busy_post || grant;
            count_reg      <= count_ext[3:0];
            dropped_reg    <= op.insert && stat.full;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_granted         = granted_reg;
    assign m_granted_id      = granted_id_reg;
    assign m_in_use          = in_use_reg;
    assign m_waiting_count   = count_reg;
    assign m_request_dropped = dropped_reg;

endmodule

`default_nettype wire

// ===== tb/cooldown_resource_arbiter_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cooldown_resource_arbiter_test
// Sends tick, request, release and cancel words under random flow control on
// both channels. A scoreboard keeps its own waiter table, clock and cooldown
// state, predicts each result word and checks it field by field.
// ---------------------------------------------------------------------------

typedef struct packed {
    logic       granted;
    logic [7:0] granted_id;
    logic       in_use;
    logic [3:0] waiting_count;
    logic       request_dropped;
} arb_result_t;

class arbiter_scoreboard;
    logic [31:0] cooldown_ms;
    logic        edf_mode;
    logic [31:0] burnout_ms;
    logic [31:0] now_ms;
    logic [31:0] freed_at_ms;
    logic        busy;
    logic        never_granted;
    logic        slot_used     [cra_pkg::WAITER_SLOTS];
    logic [7:0]  slot_client   [cra_pkg::WAITER_SLOTS];
    logic [31:0] slot_arrival  [cra_pkg::WAITER_SLOTS];
    logic [31:0] slot_deadline [cra_pkg::WAITER_SLOTS];
    arb_result_t expected_q[$];
    int          mismatches;

    function new();
        int i;
        cooldown_ms   = '0;
        edf_mode      = 1'b0;
        burnout_ms    = '0;
        now_ms        = '0;
        freed_at_ms   = '0;
        busy          = 1'b0;
        never_granted = 1'b1;
        mismatches    = 0;
        for (i = 0; i < cra_pkg::WAITER_SLOTS; i++) begin
            slot_used[i]     = 1'b0;
            slot_client[i]   = '0;
            slot_arrival[i]  = '0;
            slot_deadline[i] = '0;
        end
    endfunction

    function void write_reg(cra_pkg::cfg_reg_t addr, logic [31:0] data);
        case (addr)
            cra_pkg::CFG_COOLDOWN: cooldown_ms = data;
            cra_pkg::CFG_EDF_MODE: edf_mode    = data[0];
            cra_pkg::CFG_BURNOUT:  burnout_ms  = data;
            default: ;
        endcase
    endfunction

    // Slot a beats slot b: deadline first in EDF mode, then arrival
    function bit ranks_ahead(int a, int b);
        if (edf_mode && slot_deadline[a] != slot_deadline[b])
            return slot_deadline[a] < slot_deadline[b];
        return slot_arrival[a] < slot_arrival[b];
    endfunction

    function string describe(arb_result_t r);
        return $sformatf("granted=%0d id=%02h in_use=%0d waiting=%0d dropped=%0d",
                         r.granted, r.granted_id, r.in_use, r.waiting_count,
                         r.request_dropped);
    endfunction

    function void note_word(cra_pkg::action_t act, logic [7:0] id, logic [31:0] last_start);
        arb_result_t r;
        logic [32:0] sum;
        logic [31:0] elapsed;
        int          free_slot;
        int          victim;
        int          best;
        int          count;
        int          i;
        r         = '0;
        free_slot = -1;
        victim    = -1;
        best      = -1;
        count     = 0;
        case (act)
            cra_pkg::ACT_TICK: now_ms = now_ms + 32'd1;
            cra_pkg::ACT_REQUEST: begin
                for (i = 0; i < cra_pkg::WAITER_SLOTS; i++)
                    if (!slot_used[i] && free_slot < 0) free_slot = i;
                if (free_slot < 0) begin
                    r.request_dropped = 1'b1;
                end else begin
                    // saturate the deadline instead of wrapping
                    sum = {1'b0, last_start} + {1'b0, burnout_ms};
                    slot_used[free_slot]     = 1'b1;
                    slot_client[free_slot]   = id;
                    slot_arrival[free_slot]  = now_ms;
                    slot_deadline[free_slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
            cra_pkg::ACT_RELEASE: begin
                busy        = 1'b0;
                freed_at_ms = now_ms;
            end
            default: begin
                for (i = 0; i < cra_pkg::WAITER_SLOTS; i++)
                    if (slot_used[i] && slot_client[i] == id && victim < 0) victim = i;
                if (victim >= 0) slot_used[victim] = 1'b0;
            end
        endcase

        elapsed = now_ms - freed_at_ms;
        if (!busy && (never_granted || elapsed >= cooldown_ms)) begin
            for (i = 0; i < cra_pkg::WAITER_SLOTS; i++)
                if (slot_used[i] && (best < 0 || ranks_ahead(i, best))) best = i;
            if (best >= 0) begin
                r.granted       = 1'b1;
                r.granted_id    = slot_client[best];
                slot_used[best] = 1'b0;
                busy            = 1'b1;
                never_granted   = 1'b0;
            end
        end

        for (i = 0; i < cra_pkg::WAITER_SLOTS; i++)
            if (slot_used[i]) count++;
        r.in_use        = busy;
        r.waiting_count = 4'(count);
        expected_q.push_back(r);
    endfunction

    function void check_word(arb_result_t got);
        arb_result_t want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result word with nothing expected: %s", describe(got));
            return;
        end
        want = expected_q.pop_front();
        if (got.granted !== want.granted || got.granted_id !== want.granted_id ||
            got.in_use !== want.in_use || got.waiting_count !== want.waiting_count ||
            got.request_dropped !== want.request_dropped) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result mismatch at %0t", $realtime);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        end
    endfunction
endclass

module cooldown_resource_arbiter_test;
    import cra_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_WORDS  = 196;
    localparam int TAIL_CYCLES  = 8;

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        cfg_wr_en         = 1'b0;
    logic [1:0]  cfg_addr          = '0;
    logic [31:0] cfg_wdata         = '0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action          = '0;
    logic [7:0]  s_requester_id    = '0;
    logic [31:0] s_last_start_ms   = '0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic        m_granted;
    logic [7:0]  m_granted_id;
    logic        m_in_use;
    logic [3:0]  m_waiting_count;
    logic        m_request_dropped;

    logic        hold_req   = 1'b0;
    logic        hold_seen  = 1'b0;
    logic        tail_calm  = 1'b0;
    int          words_sent   = 0;
    int          results_seen = 0;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    int          stall_left   = 0;
    int          recv_cycles  = 0;
    int          quiet_cycles = 0;
    logic [7:0]  id_pool [6];

    arbiter_scoreboard board = new();

    cooldown_resource_arbiter i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_requester_id    (s_requester_id),
        .s_last_start_ms   (s_last_start_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted         (m_granted),
        .m_granted_id      (m_granted_id),
        .m_in_use          (m_in_use),
        .m_waiting_count   (m_waiting_count),
        .m_request_dropped (m_request_dropped)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 25;
            default: return 50;
        endcase
    endfunction

    // Monitor: both channels and the register port, sampled at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                board.write_reg(cfg_reg_t'(cfg_addr), cfg_wdata);
            if (s_valid && s_ready)
                board.note_word(action_t'(s_action), s_requester_id, s_last_start_ms);
            if (m_valid && m_ready) begin
                board.check_word({m_granted, m_granted_id, m_in_use, m_waiting_count,
                                  m_request_dropped});
                results_seen <= results_seen + 1;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    always @(posedge aclk) begin
        recv_cycles <= recv_cycles + 1;
        if (recv_cycles % 128 == 0) stall_pct <= pick_idle_pct();
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen  <= hold_req;
            stall_left <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!tail_calm && $urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(14);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic drive_word(action_t act, logic [7:0] id, logic [31:0] last_start);
        s_valid         <= 1'b1;
        s_action        <= act;
        s_requester_id  <= id;
        s_last_start_ms <= last_start;
        do @(posedge aclk); while (s_ready !== 1'b1);
        words_sent++;
        if (words_sent % 100 == 0) gap_pct = pick_idle_pct();
        if (!tail_calm && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge aclk);
        end
    endtask

    // Drop valid only if it is still up, so a following word can raise it
    // again in the same step without a second assignment
    task automatic wait_drained();
        if (s_valid)
            s_valid <= 1'b0;
        while (results_seen != words_sent) @(posedge aclk);
    endtask

    task automatic set_config(logic [31:0] cooldown, logic edf, logic [31:0] burnout);
        logic [31:0] noise;
        noise = $urandom;
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_COOLDOWN;
        cfg_wdata <= cooldown;
        @(posedge aclk);
        // only bit 0 counts for the mode register
        cfg_addr  <= CFG_EDF_MODE;
        cfg_wdata <= {noise[31:1], edf};
        @(posedge aclk);
        cfg_addr  <= CFG_BURNOUT;
        cfg_wdata <= burnout;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_words(int count, int hold_at, int pause_at);
        action_t     act;
        logic [7:0]  id;
        logic [31:0] last_start;
        int          roll;
        int          n;
        foreach (id_pool[k]) id_pool[k] = 8'($urandom);
        for (n = 0; n < count; n++) begin
            if (n == hold_at) hold_req <= ~hold_req;
            if (n == pause_at) wait_drained();
            roll = $urandom_range(99);
            if (roll < 28)      act = ACT_TICK;
            else if (roll < 63) act = ACT_REQUEST;
            else if (roll < 83) act = ACT_RELEASE;
            else                act = ACT_CANCEL;
            // mostly a small set of clients so cancels and duplicates hit
            id = ($urandom_range(9) < 8) ? id_pool[$urandom_range(5)] : 8'($urandom);
            case ($urandom_range(3))
                0:       last_start = $urandom;
                1:       last_start = board.now_ms - $urandom_range(40);
                2:       last_start = $urandom_range(200);
                default: last_start = 32'hFFFF_FFFF - $urandom_range(60);
            endcase
            drive_word(act, id, last_start);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(32'd3, 1'b1, 32'd100);
        drive_word(ACT_RELEASE, 8'h00, 32'h0000_0000);  // release with nothing ever granted
        drive_word(ACT_REQUEST, 8'hFF, 32'hFFFF_FFFF);  // deadline saturates, granted at once
        drive_word(ACT_REQUEST, 8'h00, 32'h0000_0000);
        drive_word(ACT_REQUEST, 8'h12, 32'h0000_0000);  // same deadline and arrival as 8'h00
        drive_word(ACT_REQUEST, 8'h12, 32'd50);         // second slot for one client
        drive_word(ACT_CANCEL,  8'h77, 32'h0000_0000);  // absent client
        drive_word(ACT_CANCEL,  8'h12, 32'h0000_0000);  // drop the lower of two slots
        drive_word(ACT_RELEASE, 8'h00, 32'h0000_0000);  // cooldown holds the next grant
        drive_word(ACT_TICK,    8'h00, 32'h0000_0000);
        drive_word(ACT_TICK,    8'h00, 32'h0000_0000);
        drive_word(ACT_TICK,    8'h00, 32'h0000_0000);
        // fill the table, the last request gets dropped
        drive_word(ACT_REQUEST, 8'hA0, 32'hAAAA_AAAA);
        drive_word(ACT_REQUEST, 8'hA1, 32'h5555_5555);
        drive_word(ACT_REQUEST, 8'hA2, 32'h0000_0001);
        drive_word(ACT_REQUEST, 8'hA3, 32'h8000_0000);
        drive_word(ACT_REQUEST, 8'hA4, 32'h0000_0001);
        drive_word(ACT_REQUEST, 8'hA5, 32'h7FFF_FFFF);
        drive_word(ACT_REQUEST, 8'hA6, 32'hFFFF_FF00);
        drive_word(ACT_REQUEST, 8'hA7, 32'h0000_0000);
        drive_word(ACT_RELEASE, 8'h00, 32'h0000_0000);
        drive_word(ACT_TICK,    8'h00, 32'h0000_0000);
        drive_word(ACT_TICK,    8'h00, 32'h0000_0000);
        drive_word(ACT_TICK,    8'hFF, 32'hFFFF_FFFF);
        drive_word(ACT_RELEASE, 8'h00, 32'h0000_0000);
        drive_word(ACT_RELEASE, 8'h00, 32'h0000_0000);  // release while already free

        set_config(32'd0, 1'b0, 32'd0);
        random_words(PHASE_WORDS, -1, -1);
        set_config(32'd2, 1'b1, 32'd50);
        random_words(PHASE_WORDS, 40, -1);
        set_config(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        random_words(PHASE_WORDS, -1, -1);
        set_config(32'd1, 1'b0, $urandom);
        random_words(PHASE_WORDS, -1, 100);
        set_config($urandom_range(6), 1'b1, $urandom_range(1000));
        random_words(PHASE_WORDS, -1, -1);
        set_config(32'd3, 1'b1, 32'h8000_0000);
        random_words(PHASE_WORDS, -1, -1);
        set_config(32'd0, 1'b1, 32'd10);
        tail_calm <= 1'b1;
        random_words(PHASE_WORDS, -1, -1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.expected_q.size() != 0)
            $display("%0d expected result words never arrived", board.expected_q.size());
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
